// ===== rtl/core/ahls_pkg.sv =====
// Shared types, codes and constants of the axis homing and limit supervisor.
package ahls_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_HOMING_MODE  = 3'd0;
  localparam logic [2:0] REG_SW_ACT_LOW   = 3'd1;
  localparam logic [2:0] REG_MIN_LIMIT    = 3'd2;
  localparam logic [2:0] REG_MAX_LIMIT    = 3'd3;
  localparam logic [2:0] REG_BACKOFF      = 3'd4;
  localparam logic [2:0] REG_TIMEOUT      = 3'd5;
  localparam logic [2:0] REG_SOFT_LIMITS  = 3'd6;

  // Homing modes.
  localparam logic [1:0] HM_NONE = 2'd0;
  localparam logic [1:0] HM_MIN  = 2'd1;
  localparam logic [1:0] HM_MAX  = 2'd2;

  // Input opcodes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_HOME  = 2'd1;
  localparam logic [1:0] OP_INVAL = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SEEK = 3'd1,
    PH_BACK = 3'd2,
    PH_DONE = 3'd3,
    PH_FAIL = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_BACKWARD   = 3'd1,
    CMD_FORWARD    = 3'd2,
    CMD_SET_MOVE   = 3'd3,
    CMD_FORCE_STOP = 3'd4,
    CMD_DECEL_STOP = 3'd5,
    CMD_SET_POS    = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [1:0]         homing_mode;
    logic               switch_active_low;
    logic signed [31:0] min_limit_steps;
    logic signed [31:0] max_limit_steps;
    logic [30:0]        backoff_steps;
    logic [31:0]        seek_timeout_ms;
    logic               soft_limits_on;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        now_ms;
    logic               min_switch_pin;
    logic               max_switch_pin;
    logic               motor_running;
    logic signed [1:0]  speed_sign;
    logic signed [31:0] position_steps;
    logic signed [1:0]  jog_direction;
  } item_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] new_position;
    logic signed [31:0] move_target;
    phase_t             phase;
    logic               homed;
    logic               min_hit;
    logic               max_hit;
  } res_t;

  // Clamp a 34-bit signed value into a signed range of pbits bits.
  function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v,
                                                 input int unsigned pbits);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    logic signed [33:0] r;
    hi = (34'sd1 <<< (pbits - 1)) - 34'sd1;
    lo = -hi - 34'sd1;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

endpackage

// ===== rtl/core/ahls_cfg_regs.sv =====
// Configuration register file on the APB-style port.
module ahls_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ahls_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ahls_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ahls_pkg::CFG_DATA_W-1:0]   prdata,
  output ahls_pkg::cfg_t                    cfg
);
  import ahls_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign idx   = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.homing_mode       <= HM_NONE;
      cfg_r.switch_active_low <= 1'b1;
      cfg_r.min_limit_steps   <= '0;
      cfg_r.max_limit_steps   <= '0;
      cfg_r.backoff_steps     <= '0;
      cfg_r.seek_timeout_ms   <= TIMEOUT_RESET;
      cfg_r.soft_limits_on    <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_HOMING_MODE: cfg_r.homing_mode       <= pwdata[1:0];
        REG_SW_ACT_LOW:  cfg_r.switch_active_low <= pwdata[0];
        REG_MIN_LIMIT:   cfg_r.min_limit_steps   <= pwdata;
        REG_MAX_LIMIT:   cfg_r.max_limit_steps   <= pwdata;
        REG_BACKOFF:     cfg_r.backoff_steps     <= pwdata[30:0];
        REG_TIMEOUT:     cfg_r.seek_timeout_ms   <= pwdata;
        REG_SOFT_LIMITS: cfg_r.soft_limits_on    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HOMING_MODE: prdata = {30'd0, cfg_r.homing_mode};
      REG_SW_ACT_LOW:  prdata = {31'd0, cfg_r.switch_active_low};
      REG_MIN_LIMIT:   prdata = cfg_r.min_limit_steps;
      REG_MAX_LIMIT:   prdata = cfg_r.max_limit_steps;
      REG_BACKOFF:     prdata = {1'b0, cfg_r.backoff_steps};
      REG_TIMEOUT:     prdata = cfg_r.seek_timeout_ms;
      REG_SOFT_LIMITS: prdata = {31'd0, cfg_r.soft_limits_on};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/ahls_engine.sv =====
// Homing state, seek timeout, overrun cutoff and soft-limit decision logic.
module ahls_engine #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  ahls_pkg::cfg_t  cfg,
  input  ahls_pkg::item_t item,
  output ahls_pkg::res_t  res
);
  import ahls_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        homed_r, homed_nxt;
  logic [31:0] seek_start_r, seek_start_nxt;

  logic               sw_mode;
  logic               min_hit;
  logic               max_hit;
  logic               home_hit;
  logic [31:0]        elapsed;
  logic signed [33:0] pos_w;
  logic signed [33:0] home_w;
  logic signed [33:0] back_w;
  logic signed [33:0] npos_w;
  logic signed [33:0] tgt_w;
  logic               spd_neg;
  logic               jog_neg;
  cmd_t               cmd;

  assign sw_mode  = (cfg.homing_mode == HM_MIN) || (cfg.homing_mode == HM_MAX);
  assign min_hit  = (cfg.switch_active_low ? ~item.min_switch_pin : item.min_switch_pin)
                    & sw_mode;
  assign max_hit  = (cfg.switch_active_low ? ~item.max_switch_pin : item.max_switch_pin)
                    & sw_mode;
  assign home_hit = (cfg.homing_mode == HM_MIN) ? min_hit : max_hit;
  assign elapsed  = item.now_ms - seek_start_r;
  assign pos_w    = {{2{item.position_steps[31]}}, item.position_steps};
  assign home_w   = (cfg.homing_mode == HM_MIN)
                    ? {{2{cfg.min_limit_steps[31]}}, cfg.min_limit_steps}
                    : {{2{cfg.max_limit_steps[31]}}, cfg.max_limit_steps};
  assign back_w   = {3'd0, cfg.backoff_steps};
  assign spd_neg  = item.speed_sign[1];
  assign jog_neg  = item.jog_direction[1];

  always_comb begin
    phase_nxt      = phase_r;
    homed_nxt      = homed_r;
    seek_start_nxt = seek_start_r;
    cmd            = CMD_NONE;
    npos_w         = '0;
    tgt_w          = '0;
    case (item.opcode)
      OP_HOME: begin
        if (!sw_mode) begin
          cmd       = CMD_SET_POS;
          homed_nxt = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          homed_nxt      = 1'b0;
          phase_nxt      = PH_SEEK;
          seek_start_nxt = item.now_ms;
          cmd            = (cfg.homing_mode == HM_MIN) ? CMD_BACKWARD : CMD_FORWARD;
        end
      end
      OP_INVAL: begin
        homed_nxt = 1'b0;
        phase_nxt = PH_IDLE;
      end
      OP_TICK: begin
        if (phase_r == PH_SEEK) begin
          if (home_hit) begin
            cmd       = CMD_SET_MOVE;
            npos_w    = home_w;
            tgt_w     = (cfg.homing_mode == HM_MIN) ? home_w + back_w : home_w - back_w;
            phase_nxt = PH_BACK;
          end else if (elapsed > cfg.seek_timeout_ms) begin
            cmd       = CMD_FORCE_STOP;
            npos_w    = pos_w;
            tgt_w     = pos_w;
            phase_nxt = PH_FAIL;
          end
        end else if (phase_r == PH_BACK) begin
          if (!item.motor_running) begin
            phase_nxt = PH_DONE;
            homed_nxt = 1'b1;
          end
        end
        // Running into a switch in the direction of travel cuts the motor at once.
        if (cmd == CMD_NONE && phase_nxt != PH_SEEK && sw_mode &&
            item.speed_sign != 2'sd0) begin
          if ((spd_neg && min_hit) || (!spd_neg && max_hit)) begin
            cmd    = CMD_FORCE_STOP;
            npos_w = pos_w;
            tgt_w  = pos_w;
          end
        end
        if (cmd == CMD_NONE && item.jog_direction != 2'sd0 && cfg.soft_limits_on) begin
          if ((!jog_neg && item.position_steps >= cfg.max_limit_steps) ||
              (jog_neg && item.position_steps <= cfg.min_limit_steps)) begin
            cmd    = CMD_DECEL_STOP;
            npos_w = pos_w;
            tgt_w  = pos_w;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.command      = cmd;
    res.new_position = sat_pos(npos_w, POSITION_BITS);
    res.move_target  = sat_pos(tgt_w, POSITION_BITS);
    res.phase        = phase_nxt;
    res.homed        = homed_nxt;
    res.min_hit      = min_hit;
    res.max_hit      = max_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      homed_r      <= 1'b0;
      seek_start_r <= '0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      homed_r      <= homed_nxt;
      seek_start_r <= seek_start_nxt;
    end
  end

endmodule

// ===== rtl/core/axis_homing_and_limit_supervisor.sv =====
// Top level of the axis homing and limit supervisor: channel registers and assertions.
//
//   Channel  Handshake            Direction  Content
//   in_      in_valid / in_stall  into       opcode, time, switch pins, motion status
//   out_     out_valid/out_stall  out of     motion command, positions, homing status
//   cfg_     APB psel/penable     into       seven configuration registers
//
// One transaction is accepted per cycle while the result is not stalled; it passes
// from the input register through the decision logic into the result register.
// Homing state updates as the transaction moves from the input to the result register.
// Reset (rst_n low, synchronous) empties both registers and returns homing to idle.
// A stalled result holds; an empty input register still takes one transaction, and
// in_stall then stays high until the result is taken.
module axis_homing_and_limit_supervisor #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic [31:0]                     in_now_ms,
  input  logic                            in_min_switch_pin,
  input  logic                            in_max_switch_pin,
  input  logic                            in_motor_running,
  input  logic signed [1:0]               in_speed_sign,
  input  logic signed [31:0]              in_position_steps,
  input  logic signed [1:0]               in_jog_direction,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_command,
  output logic signed [31:0]              out_new_position,
  output logic signed [31:0]              out_move_target,
  output logic [2:0]                      out_homing_phase_out,
  output logic                            out_homed_out,
  output logic                            out_min_switch_hit,
  output logic                            out_max_switch_hit,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ahls_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ahls_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ahls_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import ahls_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  in_vld_r, in_vld_nxt;
  res_t  res;
  res_t  res_r;
  logic  out_vld_r, out_vld_nxt;
  logic  adv;
  logic  in_take;

  assign cfg_pready = 1'b1;

  ahls_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ahls_engine #(
    .POSITION_BITS (POSITION_BITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  assign adv         = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall    = in_vld_r & ~adv;
  assign in_take     = in_valid & ~in_stall;
  assign in_vld_nxt  = in_take | (in_vld_r & ~adv);
  assign out_vld_nxt = adv | (out_vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode         <= in_opcode;
      item_r.now_ms         <= in_now_ms;
      item_r.min_switch_pin <= in_min_switch_pin;
      item_r.max_switch_pin <= in_max_switch_pin;
      item_r.motor_running  <= in_motor_running;
      item_r.speed_sign     <= in_speed_sign;
      item_r.position_steps <= in_position_steps;
      item_r.jog_direction  <= in_jog_direction;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_command          = res_r.command;
  assign out_new_position     = res_r.new_position;
  assign out_move_target      = res_r.move_target;
  assign out_homing_phase_out = res_r.phase;
  assign out_homed_out        = res_r.homed;
  assign out_min_switch_hit   = res_r.min_hit;
  assign out_max_switch_hit   = res_r.max_hit;

  // The homed flag is only ever set on entering the done phase.
  a_homed_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.homed |-> res_r.phase == PH_DONE)
    else $error("homed flag set outside the done phase");

  // A set-and-move command is only issued when the switch ends the seek.
  a_setmove_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.command == CMD_SET_MOVE |-> res_r.phase == PH_BACK)
    else $error("set-and-move command outside backing off");

  // The input side stalls only while it holds a transaction that cannot move on.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a blocked transaction");

  // A stalled result register keeps its transaction.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(res_r))
    else $error("stalled result changed");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the axis homing and limit supervisor.
module testbench;
  import ahls_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned SEGMENTS      = 14;
  localparam int unsigned SEGMENT_ITEMS = 100;
  localparam logic [1:0]  HM_UNUSED     = 2'd3;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
  localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_opcode;
  logic [31:0] in_now_ms;
  logic in_min_switch_pin;
  logic in_max_switch_pin;
  logic in_motor_running;
  logic signed [1:0] in_speed_sign;
  logic signed [31:0] in_position_steps;
  logic signed [1:0] in_jog_direction;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_command;
  logic signed [31:0] out_new_position;
  logic signed [31:0] out_move_target;
  logic [2:0] out_homing_phase_out;
  logic out_homed_out;
  logic out_min_switch_hit;
  logic out_max_switch_hit;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Shadow copy of the supervisor: registers and homing state.
  cfg_t regs;
  phase_t phase;
  logic homed;
  logic [31:0] seek_t;

  res_t expected_q[$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned idle_cycles;
  logic idling;
  logic [31:0] clock_ms;

  axis_homing_and_limit_supervisor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_now_ms           (in_now_ms),
    .in_min_switch_pin   (in_min_switch_pin),
    .in_max_switch_pin   (in_max_switch_pin),
    .in_motor_running    (in_motor_running),
    .in_speed_sign       (in_speed_sign),
    .in_position_steps   (in_position_steps),
    .in_jog_direction    (in_jog_direction),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_command         (out_command),
    .out_new_position    (out_new_position),
    .out_move_target     (out_move_target),
    .out_homing_phase_out(out_homing_phase_out),
    .out_homed_out       (out_homed_out),
    .out_min_switch_hit  (out_min_switch_hit),
    .out_max_switch_hit  (out_max_switch_hit),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic switch_homing();
    return regs.homing_mode == HM_MIN || regs.homing_mode == HM_MAX;
  endfunction

  function automatic logic triggered(input logic pin);
    return (regs.switch_active_low ? !pin : pin) && switch_homing();
  endfunction

  function automatic logic signed [31:0] clamp_pos(input logic signed [33:0] v);
    if (v > POS_MAX) return POS_MAX[31:0];
    if (v < POS_MIN) return POS_MIN[31:0];
    return v[31:0];
  endfunction

  // Advances the shadow state by one transaction and returns the command it causes.
  function automatic res_t next_command(input item_t it);
    res_t r;
    logic mn;
    logic mx;
    logic hit;
    logic [31:0] elapsed;
    logic signed [33:0] pos_w;
    logic signed [33:0] home_w;
    logic signed [33:0] step_w;
    logic signed [33:0] npos;
    logic signed [33:0] tgt;
    mn = triggered(it.min_switch_pin);
    mx = triggered(it.max_switch_pin);
    pos_w = 34'($signed(it.position_steps));
    npos = '0;
    tgt = '0;
    r.command = CMD_NONE;
    case (it.opcode)
      OP_HOME: begin
        if (!switch_homing()) begin
          r.command = CMD_SET_POS;
          homed = 1'b1;
          phase = PH_DONE;
        end else begin
          homed = 1'b0;
          phase = PH_SEEK;
          seek_t = it.now_ms;
          r.command = (regs.homing_mode == HM_MIN) ? CMD_BACKWARD : CMD_FORWARD;
        end
      end
      OP_INVAL: begin
        homed = 1'b0;
        phase = PH_IDLE;
      end
      OP_TICK: begin
        if (phase == PH_SEEK) begin
          hit = (regs.homing_mode == HM_MIN) ? mn : mx;
          elapsed = it.now_ms - seek_t;
          if (hit) begin
            if (regs.homing_mode == HM_MIN) begin
              home_w = 34'($signed(regs.min_limit_steps));
              step_w = $signed({3'b000, regs.backoff_steps});
            end else begin
              home_w = 34'($signed(regs.max_limit_steps));
              step_w = -$signed({3'b000, regs.backoff_steps});
            end
            r.command = CMD_SET_MOVE;
            npos = home_w;
            tgt = home_w + step_w;
            phase = PH_BACK;
          end else if (elapsed > regs.seek_timeout_ms) begin
            r.command = CMD_FORCE_STOP;
            npos = pos_w;
            tgt = pos_w;
            phase = PH_FAIL;
          end
        end else if (phase == PH_BACK && !it.motor_running) begin
          phase = PH_DONE;
          homed = 1'b1;
        end
        // Overrun cutoff: moving into a triggered switch outside of the seek.
        if (r.command == CMD_NONE && phase != PH_SEEK && switch_homing() &&
            it.speed_sign != '0) begin
          if ((it.speed_sign[1] && mn) || (!it.speed_sign[1] && mx)) begin
            r.command = CMD_FORCE_STOP;
            npos = pos_w;
            tgt = pos_w;
          end
        end
        if (r.command == CMD_NONE && it.jog_direction != '0 && regs.soft_limits_on) begin
          if ((!it.jog_direction[1] && pos_w >= $signed(regs.max_limit_steps)) ||
              (it.jog_direction[1] && pos_w <= $signed(regs.min_limit_steps))) begin
            r.command = CMD_DECEL_STOP;
            npos = pos_w;
            tgt = pos_w;
          end
        end
      end
      default: ;
    endcase
    r.new_position = clamp_pos(npos);
    r.move_target = clamp_pos(tgt);
    r.phase = phase;
    r.homed = homed;
    r.min_hit = mn;
    r.max_hit = mx;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: command %0d", out_command);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("command", 32'(want.command), 32'(out_command));
        check_field("new_position", want.new_position, out_new_position);
        check_field("move_target", want.move_target, out_move_target);
        check_field("homing_phase_out", 32'(want.phase), 32'(out_homing_phase_out));
        check_field("homed_out", 32'(want.homed), 32'(out_homed_out));
        check_field("min_switch_hit", 32'(want.min_hit), 32'(out_min_switch_hit));
        check_field("max_switch_hit", 32'(want.max_hit), 32'(out_max_switch_hit));
      end
    end
  end

  // Ends the run when no transaction of any kind has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input item_t it);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= it.opcode;
    in_now_ms         <= it.now_ms;
    in_min_switch_pin <= it.min_switch_pin;
    in_max_switch_pin <= it.max_switch_pin;
    in_motor_running  <= it.motor_running;
    in_speed_sign     <= it.speed_sign;
    in_position_steps <= it.position_steps;
    in_jog_direction  <= it.jog_direction;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(next_command(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_HOMING_MODE: regs.homing_mode = val[1:0];
      REG_SW_ACT_LOW:  regs.switch_active_low = val[0];
      REG_MIN_LIMIT:   regs.min_limit_steps = val;
      REG_MAX_LIMIT:   regs.max_limit_steps = val;
      REG_BACKOFF:     regs.backoff_steps = val[30:0];
      REG_TIMEOUT:     regs.seek_timeout_ms = val;
      REG_SOFT_LIMITS: regs.soft_limits_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only once every result is out and the pipeline has drained.
  task automatic load_regs(input cfg_t c);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_HOMING_MODE, 32'(c.homing_mode));
    write_reg(REG_SW_ACT_LOW, 32'(c.switch_active_low));
    write_reg(REG_MIN_LIMIT, c.min_limit_steps);
    write_reg(REG_MAX_LIMIT, c.max_limit_steps);
    write_reg(REG_BACKOFF, 32'(c.backoff_steps));
    write_reg(REG_TIMEOUT, c.seek_timeout_ms);
    write_reg(REG_SOFT_LIMITS, 32'(c.soft_limits_on));
  endtask

  function automatic item_t make_item(input logic [1:0] op, input logic [31:0] now,
                                      input logic minp, input logic maxp, input logic run,
                                      input logic signed [1:0] spd,
                                      input logic signed [31:0] pos,
                                      input logic signed [1:0] jog);
    item_t it;
    it.opcode = op;
    it.now_ms = now;
    it.min_switch_pin = minp;
    it.max_switch_pin = maxp;
    it.motor_running = run;
    it.speed_sign = spd;
    it.position_steps = pos;
    it.jog_direction = jog;
    return it;
  endfunction

  function automatic item_t random_tick();
    item_t it;
    clock_ms += $urandom_range(0, 3);
    it.opcode = OP_TICK;
    it.now_ms = clock_ms;
    it.min_switch_pin = 1'($urandom_range(0, 1));
    it.max_switch_pin = 1'($urandom_range(0, 1));
    it.motor_running = 1'($urandom_range(0, 1));
    it.speed_sign = 2'($urandom_range(0, 3));
    it.jog_direction = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: it.position_steps = regs.min_limit_steps;
      1: it.position_steps = regs.max_limit_steps;
      2: it.position_steps = regs.min_limit_steps - 32'sd1;
      3: it.position_steps = regs.max_limit_steps + 32'sd1;
      default: it.position_steps = $urandom();
    endcase
    return it;
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c.homing_mode = HM_MIN;
      4, 5, 6, 7: c.homing_mode = HM_MAX;
      8: c.homing_mode = HM_NONE;
      default: c.homing_mode = HM_UNUSED;
    endcase
    c.switch_active_low = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: begin
        c.min_limit_steps = 32'(-int'($urandom_range(0, 1000)));
        c.max_limit_steps = 32'($urandom_range(0, 1000));
      end
      1: begin
        c.min_limit_steps = $urandom();
        c.max_limit_steps = $urandom();
      end
      2: begin
        c.min_limit_steps = POS_MIN[31:0];
        c.max_limit_steps = POS_MAX[31:0];
      end
      default: begin
        c.min_limit_steps = POS_MAX[31:0];
        c.max_limit_steps = POS_MIN[31:0];
      end
    endcase
    case ($urandom_range(0, 4))
      0: c.backoff_steps = '0;
      1: c.backoff_steps = '1;
      2: c.backoff_steps = 31'($urandom());
      default: c.backoff_steps = 31'($urandom_range(0, 500));
    endcase
    case ($urandom_range(0, 7))
      0: c.seek_timeout_ms = '0;
      1: c.seek_timeout_ms = '1;
      2: c.seek_timeout_ms = TIMEOUT_RESET;
      default: c.seek_timeout_ms = $urandom_range(0, 30);
    endcase
    c.soft_limits_on = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Reset register values: no switch homing, so start homing only zeroes the position.
  task automatic test_no_switch_homing();
    send_item(make_item(OP_TICK, '0, 1'b0, 1'b0, 1'b0, 2'sd0, '0, 2'sd0));
    send_item(make_item(OP_TICK, '1, 1'b1, 1'b1, 1'b1, -2'sd1, 32'sh7FFF_FFFF, -2'sd2));
    send_item(make_item(OP_HOME, 32'd5, 1'b0, 1'b0, 1'b0, 2'sd1, 32'sd77, 2'sd0));
    send_item(make_item(OP_UNUSED, 32'd6, 1'b0, 1'b1, 1'b1, 2'sd1,
                        32'sh8000_0000, 2'sd1));
    send_item(make_item(OP_INVAL, 32'd7, 1'b0, 1'b0, 1'b0, 2'sd0, '0, 2'sd0));
    load_regs('{HM_UNUSED, 1'b1, '0, '0, '0, TIMEOUT_RESET, 1'b0});
    send_item(make_item(OP_HOME, 32'd8, 1'b0, 1'b0, 1'b0, 2'sd0, 32'sd9, 2'sd0));
  endtask

  // Min homing whose backoff target overflows and saturates high.
  task automatic test_min_homing();
    load_regs('{HM_MIN, 1'b1, 32'sh7FFF_FFFF, '0, 31'h7FFF_FFFF, TIMEOUT_RESET, 1'b0});
    send_item(make_item(OP_HOME, 32'd100, 1'b1, 1'b1, 1'b0, 2'sd0, 32'sd3, 2'sd0));
    send_item(make_item(OP_TICK, 32'd200, 1'b1, 1'b1, 1'b1, -2'sd1, 32'sd3, 2'sd0));
    send_item(make_item(OP_TICK, 32'd300, 1'b0, 1'b1, 1'b1, -2'sd1, 32'sd3, 2'sd0));
    send_item(make_item(OP_TICK, 32'd301, 1'b0, 1'b1, 1'b1, -2'sd1, 32'sd4, 2'sd0));
    send_item(make_item(OP_TICK, 32'd302, 1'b1, 1'b1, 1'b0, 2'sd0, 32'sd5, 2'sd0));
  endtask

  // Max homing: a seek that times out across the wrap of the millisecond clock,
  // then one that hits the switch with the target saturating low.
  task automatic test_max_homing_timeout();
    load_regs('{HM_MAX, 1'b0, '0, 32'sh8000_0000, 31'h7FFF_FFFF, 32'd5, 1'b0});
    send_item(make_item(OP_HOME, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 2'sd0, 32'sd1, 2'sd0));
    send_item(make_item(OP_TICK, 32'd3, 1'b0, 1'b0, 1'b1, 2'sd1, 32'sd2, 2'sd0));
    send_item(make_item(OP_TICK, 32'd4, 1'b0, 1'b0, 1'b1, 2'sd1, 32'sd3, 2'sd0));
    send_item(make_item(OP_HOME, 32'd10, 1'b0, 1'b0, 1'b0, 2'sd0, 32'sd3, 2'sd0));
    send_item(make_item(OP_TICK, 32'd11, 1'b0, 1'b1, 1'b1, 2'sd1, 32'sd3, 2'sd0));
  endtask

  task automatic test_switch_overrun_and_soft_limits();
    load_regs('{HM_MIN, 1'b0, -32'sd100, 32'sd100, '0, '1, 1'b1});
    send_item(make_item(OP_TICK, 32'd1, 1'b0, 1'b1, 1'b1, 2'sd1, 32'sd50, 2'sd0));
    send_item(make_item(OP_TICK, 32'd2, 1'b1, 1'b0, 1'b1, -2'sd2, -32'sd50, 2'sd0));
    send_item(make_item(OP_TICK, 32'd3, 1'b0, 1'b0, 1'b1, 2'sd0, 32'sd100, 2'sd1));
    send_item(make_item(OP_TICK, 32'd4, 1'b0, 1'b0, 1'b1, 2'sd0, -32'sd100, -2'sd2));
    send_item(make_item(OP_TICK, 32'd5, 1'b0, 1'b0, 1'b1, 2'sd0, -32'sd99, -2'sd1));
    send_item(make_item(OP_TICK, 32'd6, 1'b0, 1'b0, 1'b1, 2'sd0, 32'sd99, 2'sd1));
  endtask

  // A full homing attempt: start, quiet seek ticks, maybe the switch, then backoff.
  task automatic homing_sequence();
    item_t it;
    logic quiet_level;
    quiet_level = regs.switch_active_low;
    it = random_tick();
    it.opcode = OP_HOME;
    send_item(it);
    repeat ($urandom_range(0, 6)) begin
      it = random_tick();
      if (regs.homing_mode == HM_MIN) it.min_switch_pin = quiet_level;
      else it.max_switch_pin = quiet_level;
      // Land right on the timeout boundary now and then.
      if ($urandom_range(0, 5) == 0) begin
        it.now_ms = seek_t + regs.seek_timeout_ms + 32'($urandom_range(0, 1));
        clock_ms = it.now_ms;
      end
      send_item(it);
    end
    if ($urandom_range(0, 3) != 0) begin
      it = random_tick();
      if (regs.homing_mode == HM_MIN) it.min_switch_pin = !quiet_level;
      else it.max_switch_pin = !quiet_level;
      send_item(it);
      repeat ($urandom_range(0, 4)) begin
        it = random_tick();
        it.motor_running = 1'b1;
        send_item(it);
      end
      it = random_tick();
      it.motor_running = 1'b0;
      send_item(it);
    end
    repeat ($urandom_range(0, 8)) send_item(random_tick());
  endtask

  task automatic test_random_sequences();
    item_t it;
    int unsigned seg_end;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      load_regs(random_regs());
      clock_ms = $urandom();
      idling = (seg < SEGMENTS - 2) && ($urandom_range(0, 3) != 0);
      seg_end = items_sent + SEGMENT_ITEMS;
      while (items_sent < seg_end) begin
        if ($urandom_range(0, 4) != 0) begin
          homing_sequence();
        end else begin
          repeat ($urandom_range(1, 10)) begin
            it = random_tick();
            it.opcode = 2'($urandom_range(0, 3));
            send_item(it);
          end
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_TICK;
    in_now_ms = '0;
    in_min_switch_pin = 1'b0;
    in_max_switch_pin = 1'b0;
    in_motor_running = 1'b0;
    in_speed_sign = '0;
    in_position_steps = '0;
    in_jog_direction = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idling = 1'b0;
    fail_count = 0;
    items_sent = 0;
    clock_ms = '0;
    regs = '{HM_NONE, 1'b1, '0, '0, '0, TIMEOUT_RESET, 1'b0};
    phase = PH_IDLE;
    homed = 1'b0;
    seek_t = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_no_switch_homing();
    test_min_homing();
    test_max_homing_timeout();
    test_switch_overrun_and_soft_limits();
    test_random_sequences();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ahls_pkg.sv
rtl/core/ahls_cfg_regs.sv
rtl/core/ahls_engine.sv
rtl/core/axis_homing_and_limit_supervisor.sv
dv/testbench.sv
